FILE: design/rmc_pkg.sv
package rmc_pkg;

   localparam int unsigned WinDepth = 13;
   localparam int unsigned ShortAt = 5;
   localparam int unsigned ShortSpan = 8;
   localparam logic [3:0] ShortMinCount = 4'd7;
   localparam logic [3:0] LongMinCount = 4'd12;
   localparam logic [3:0] CountMax = 4'd15;

   // Index 0 is the oldest byte of the window.
   typedef logic [0:WinDepth-1][7:0] window_type;

   typedef enum logic [3:0] {
      METHOD_NONE     = 4'd0,
      METHOD_OPTION   = 4'd1,
      METHOD_DESCRIBE = 4'd2,
      METHOD_SETUP    = 4'd3,
      METHOD_PLAY     = 4'd4,
      METHOD_PAUSE    = 4'd5,
      METHOD_TEARDOWN = 4'd6,
      METHOD_GET_PARAM = 4'd7,
      METHOD_SET_PARAM = 4'd8
   } method_type;

   typedef struct packed {
      logic       found;
      method_type code;
   } result_type;

   localparam window_type KW_OPTION = '{8'h4f, 8'h50, 8'h54, 8'h49, 8'h4f, 8'h4e,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam window_type KW_DESCRIBE = '{8'h44, 8'h45, 8'h53, 8'h43, 8'h52, 8'h49,
      8'h42, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam window_type KW_SETUP = '{8'h53, 8'h45, 8'h54, 8'h55, 8'h50,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam window_type KW_PLAY = '{8'h50, 8'h4c, 8'h41, 8'h59,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam window_type KW_PAUSE = '{8'h50, 8'h41, 8'h55, 8'h53, 8'h45,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam window_type KW_TEARDOWN = '{8'h54, 8'h45, 8'h41, 8'h52, 8'h44, 8'h4f,
      8'h57, 8'h4e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam window_type KW_GET_PARAM = '{8'h47, 8'h45, 8'h54, 8'h5f, 8'h50, 8'h41,
      8'h52, 8'h41, 8'h4d, 8'h45, 8'h54, 8'h45, 8'h52};
   localparam window_type KW_SET_PARAM = '{8'h53, 8'h45, 8'h54, 8'h5f, 8'h50, 8'h41,
      8'h52, 8'h41, 8'h4d, 8'h45, 8'h54, 8'h45, 8'h52};

   // Compares a short keyword against the newest eight bytes of the window.
   function automatic logic short_hit(window_type win, window_type kw, logic [3:0] len);
      logic hit;
      hit = 1'b1;
      for (int i = 0; i < ShortSpan; i++) begin
         if (4'(i) < len && win[ShortAt + i] != kw[i]) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   // Compares a thirteen-byte keyword against the whole window.
   function automatic logic long_hit(window_type win, window_type kw);
      logic hit;
      hit = 1'b1;
      for (int i = 0; i < WinDepth; i++) begin
         if (win[i] != kw[i]) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage

FILE: design/rmc_cell.sv
module rmc_cell
   import rmc_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] prev_byte,
   output logic [7:0] held_byte
);

   logic [7:0] hold_ff;
   logic [7:0] hold_in;

   always_comb begin
      hold_in = shift_en ? prev_byte : hold_ff;
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign held_byte = hold_ff;

endmodule

FILE: design/rmc_tracker.sv
module rmc_tracker
   import rmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       last,
   input  window_type win_next,
   output result_type result
);

   logic [3:0] count_ff;
   logic [3:0] count_in;
   logic       found_ff;
   logic       found_in;
   method_type code_ff;
   method_type code_in;
   method_type short_code;
   method_type long_code;
   method_type hit_code;

   always_comb begin
      short_code = METHOD_NONE;
      if (short_hit(win_next, KW_OPTION, 4'd6)) begin
         short_code = METHOD_OPTION;
      end else if (short_hit(win_next, KW_DESCRIBE, 4'd8)) begin
         short_code = METHOD_DESCRIBE;
      end else if (short_hit(win_next, KW_SETUP, 4'd5)) begin
         short_code = METHOD_SETUP;
      end else if (short_hit(win_next, KW_PLAY, 4'd4)) begin
         short_code = METHOD_PLAY;
      end else if (short_hit(win_next, KW_PAUSE, 4'd5)) begin
         short_code = METHOD_PAUSE;
      end else if (short_hit(win_next, KW_TEARDOWN, 4'd8)) begin
         short_code = METHOD_TEARDOWN;
      end

      long_code = METHOD_NONE;
      if (long_hit(win_next, KW_GET_PARAM)) begin
         long_code = METHOD_GET_PARAM;
      end else if (long_hit(win_next, KW_SET_PARAM)) begin
         long_code = METHOD_SET_PARAM;
      end

      // The count gates each test so that only bytes of this message take part.
      hit_code = METHOD_NONE;
      if (count_ff >= ShortMinCount && short_code != METHOD_NONE) begin
         hit_code = short_code;
      end else if (count_ff >= LongMinCount) begin
         hit_code = long_code;
      end

      found_in = found_ff;
      code_in  = code_ff;
      if (!found_ff && hit_code != METHOD_NONE) begin
         found_in = 1'b1;
         code_in  = hit_code;
      end

      result.found = found_in;
      result.code  = found_in ? code_in : METHOD_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
         code_ff  <= METHOD_NONE;
      end else if (accept) begin
         if (last) begin
            count_ff <= '0;
            found_ff <= 1'b0;
            code_ff  <= METHOD_NONE;
         end else begin
            count_ff <= count_in;
            found_ff <= found_in;
            code_ff  <= code_in;
         end
      end
   end

   always_comb begin
      count_in = (count_ff < CountMax) ? count_ff + 4'd1 : count_ff;
   end

endmodule

FILE: design/rtsp_method_classifier_top.sv
// RTSP method classifier.
// The message text enters one byte per transfer on the req_ channel
// (req_data_byte, with req_last_byte set on the final byte). Exactly one
// result leaves on the rsp_ channel for each message, in the cycle after its
// last byte is taken: rsp_method_code gives the method of the keyword that
// starts earliest in the message (0 when none), and rsp_found is set when a
// keyword was recognised. Bytes that are not last produce no result.
// Throughput is one byte per cycle while ready: a row of thirteen byte cells
// shifts on every transfer and all keyword compares are made on the shifted
// window in the same cycle, so the rate is set by that single compare stage.
// The result sits in an output register; a new byte is still taken while the
// receiver holds off, except when that register is full and not being
// emptied, in which case req_ready drops until rsp_ready returns.
// Reset clears the position count, the latched match and the output valid
// flag; after each last byte the block is ready for the next message with
// no gap, unless the unread result holds req_ready low.
module rtsp_method_classifier_top
   import rmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_method_code,
   output logic       rsp_found
);

   logic       accept;
   window_type win_cur;
   window_type win_next;
   result_type result;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   genvar g;
   generate
      for (g = 0; g < WinDepth; g++) begin : g_cell
         if (g == WinDepth - 1) begin : g_head
            rmc_cell u_cell (
               .clock     (clock),
               .shift_en  (accept),
               .prev_byte (req_data_byte),
               .held_byte (win_cur[g])
            );
         end else begin : g_body
            rmc_cell u_cell (
               .clock     (clock),
               .shift_en  (accept),
               .prev_byte (win_cur[g+1]),
               .held_byte (win_cur[g])
            );
         end
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < WinDepth - 1; i++) begin
         win_next[i] = win_cur[i+1];
      end
      win_next[WinDepth-1] = req_data_byte;
   end

   rmc_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .last     (req_last_byte),
      .win_next (win_next),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && req_last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_method_code = rsp_data_ff.code;
   assign rsp_found       = rsp_data_ff.found;

   a_last_gives_result : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_byte) |=> rsp_valid)
      else $error("last byte transfer did not produce a result");

   a_inner_no_result : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last_byte) |=> !rsp_valid)
      else $error("result appeared for a byte that was not last");

   a_found_has_code : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_method_code != METHOD_NONE))
      else $error("found set with no method code");

   a_none_has_no_code : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_method_code == METHOD_NONE))
      else $error("method code given without a match");

endmodule
